[rtl/swam_pkg.sv]
// Shared types, constants and helpers of the sliding-window anagram matcher.
package swam_pkg;

  localparam int unsigned MAX_PATTERN = 256;
  localparam int unsigned ALPHABET    = 26;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int unsigned BAL_W       = CNT_W + 1;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CNT_W:0]          wide_t;
  typedef logic signed [BAL_W-1:0] bal_t;
  typedef logic [LETTER_W-1:0]     letter_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    letter_t          letter;
  } in_item_t;

  typedef struct packed {
    logic window_match;
    logic found;
    logic pattern_overflow;
  } out_item_t;

  typedef struct packed {
    logic    we;
    ptr_t    waddr;
    letter_t wdata;
    ptr_t    raddr;
  } hist_req_t;

  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(MAX_PATTERN - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // Slot of the oldest window letter once the write pointer has advanced.
  function automatic ptr_t oldest_idx(ptr_t wp, cnt_t psize);
    wide_t nxt;
    wide_t pm;
    ptr_t  r;
    nxt = wide_t'(ptr_next(wp));
    pm  = (psize == cnt_t'(MAX_PATTERN)) ? '0 : wide_t'(psize);
    if (nxt >= pm) begin
      r = ptr_t'(nxt - pm);
    end else begin
      r = ptr_t'(nxt + wide_t'(MAX_PATTERN) - pm);
    end
    return r;
  endfunction

endpackage

[rtl/swam_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swam_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 256,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/swam_core.sv]
// Histogram, counters and history control of the anagram matcher.
module swam_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                exec_i,
  input  swam_pkg::in_item_t  item_i,
  input  swam_pkg::letter_t   hist_rdata_i,
  output swam_pkg::hist_req_t hist_req_o,
  output swam_pkg::out_item_t result_o
);
  import swam_pkg::*;

  ptr_t    wp_q, wp_d;
  cnt_t    psize_q, psize_d;
  cnt_t    fill_q, fill_d;
  cnt_t    rem_q, rem_d;
  logic    seen_q, seen_d;
  bal_t    bal_q [ALPHABET];
  bal_t    bal_d [ALPHABET];
  logic    fwd_hit_q, fwd_hit_d;
  letter_t fwd_data_q;

  logic    letter_ok, txt_full;
  logic    inc_c, dec_c, inc_old, clr;
  bal_t    bal_c, bal_old, bal_old_after;
  letter_t hist_rd, old_letter;
  ptr_t    idx;
  cnt_t    fill_inc, rem1;
  logic    match, overflow;

  always_comb begin
    letter_ok = item_i.letter < letter_t'(ALPHABET);
    hist_rd   = fwd_hit_q ? fwd_data_q : hist_rdata_i;
    idx       = oldest_idx(wp_q, psize_q);
    // a one-letter window drops the letter it has just taken
    old_letter = (idx == wp_q) ? item_i.letter : hist_rd;

    bal_c   = '0;
    bal_old = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (item_i.letter == letter_t'(i)) begin
        bal_c = bal_q[i];
      end
      if (old_letter == letter_t'(i)) begin
        bal_old = bal_q[i];
      end
    end
    bal_old_after = (old_letter == item_i.letter) ? bal_old - bal_t'(1) : bal_old;

    fill_inc = fill_q + cnt_t'(1);
    txt_full = fill_inc >= psize_q;
    rem1     = rem_q - cnt_t'(bal_c > bal_t'(0));

    wp_d     = wp_q;
    psize_d  = psize_q;
    fill_d   = fill_q;
    rem_d    = rem_q;
    seen_d   = seen_q;
    inc_c    = 1'b0;
    dec_c    = 1'b0;
    inc_old  = 1'b0;
    clr      = 1'b0;
    match    = 1'b0;
    overflow = 1'b0;

    hist_req_o.we    = 1'b0;
    hist_req_o.waddr = wp_q;
    hist_req_o.wdata = item_i.letter;

    if (exec_i) begin
      case (item_i.command)
        CMD_CLEAR: begin
          clr     = 1'b1;
          wp_d    = '0;
          psize_d = '0;
          fill_d  = '0;
          rem_d   = '0;
          seen_d  = 1'b0;
        end
        CMD_PATTERN: begin
          if (letter_ok) begin
            if (psize_q == cnt_t'(MAX_PATTERN)) begin
              overflow = 1'b1;
            end else begin
              inc_c   = 1'b1;
              rem_d   = rem_q + cnt_t'(bal_c >= bal_t'(0));
              psize_d = psize_q + cnt_t'(1);
            end
          end
        end
        CMD_TEXT: begin
          if (letter_ok) begin
            if (psize_q == '0) begin
              match = 1'b1;
            end else begin
              dec_c         = 1'b1;
              hist_req_o.we = 1'b1;
              wp_d          = ptr_next(wp_q);
              match         = (rem1 == '0);
              if (txt_full) begin
                inc_old = 1'b1;
                rem_d   = rem1 + cnt_t'(bal_old_after >= bal_t'(0));
                fill_d  = psize_q - cnt_t'(1);
              end else begin
                rem_d  = rem1;
                fill_d = fill_inc;
              end
            end
            if (match) begin
              seen_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    for (int i = 0; i < ALPHABET; i++) begin
      bal_d[i] = bal_q[i];
      if (clr) begin
        bal_d[i] = '0;
      end else begin
        if (inc_c && item_i.letter == letter_t'(i)) begin
          bal_d[i] = bal_d[i] + bal_t'(1);
        end
        if (dec_c && item_i.letter == letter_t'(i)) begin
          bal_d[i] = bal_d[i] - bal_t'(1);
        end
        if (inc_old && old_letter == letter_t'(i)) begin
          bal_d[i] = bal_d[i] + bal_t'(1);
        end
      end
    end

    // read ahead for the next item, forwarding a same-cycle write
    hist_req_o.raddr = oldest_idx(wp_d, psize_d);
    fwd_hit_d        = hist_req_o.we && (hist_req_o.waddr == hist_req_o.raddr);

    result_o.window_match     = match;
    result_o.found            = seen_d;
    result_o.pattern_overflow = overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      psize_q   <= '0;
      fill_q    <= '0;
      rem_q     <= '0;
      seen_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
      for (int i = 0; i < ALPHABET; i++) begin
        bal_q[i] <= '0;
      end
    end else begin
      wp_q      <= wp_d;
      psize_q   <= psize_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      seen_q    <= seen_d;
      fwd_hit_q <= fwd_hit_d;
      for (int i = 0; i < ALPHABET; i++) begin
        bal_q[i] <= bal_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= hist_req_o.wdata;
  end

endmodule

[rtl/sliding_window_anagram_matcher_top.sv]
// Top level of the sliding-window anagram matcher: handshake registers and history RAM.
//
// Streaming anagram search over letter codes a=0 .. z=25. A clear command
// empties all state; pattern letters build a per-letter histogram (up to
// MAX_PATTERN letters, further ones are dropped and flagged with
// pattern_overflow); each text letter slides a window of pattern length over
// the text and returns window_match when the window ending at that letter is a
// permutation of the pattern, together with a sticky found flag. Every input
// transfer yields exactly one result transfer, in order. An item is taken into
// the input register, handled by the histogram and counter logic, and its result
// held in the output register; a result is offered once that register has taken
// it, which a stalled output can delay. One item may be transferred in every
// cycle while the output is not stalled: the rate is set by the histogram update
// and the one read per cycle of the letter-history RAM, which is read ahead for
// the next item with a write bypass.
// The input side stalls only while an item waits and the output register is
// full and stalled. The history RAM needs no clearing after reset or clear.
module sliding_window_anagram_matcher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swam_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swam_pkg::out_item_t out_item_o
);
  import swam_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      exec;
  out_item_t result;
  hist_req_t hist_req;
  letter_t   hist_rdata;

  // Advance the held item when the output register is free or being drained.
  assign exec       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (exec) begin
      out_item_q <= result;
    end
  end

  swam_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exec_i       (exec),
    .item_i       (in_item_q),
    .hist_rdata_i (hist_rdata),
    .hist_req_o   (hist_req),
    .result_o     (result)
  );

  // Ring of the letters now in the window.
  swam_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_req.we),
    .waddr_i (hist_req.waddr),
    .wdata_i (hist_req.wdata),
    .raddr_i (hist_req.raddr),
    .rdata_o (hist_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/swam_checker.sv]
// Port-level checks of the anagram matcher and their binding to the top level.
module swam_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input swam_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input swam_pkg::out_item_t out_item_o
);
  import swam_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or vanished");

  // The input side stalls only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A matching window always sets the sticky flag in the same result.
  a_match_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.window_match |-> out_item_o.found)
    else $error("window match without found");

  // An overflow result is never a match.
  a_overflow_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pattern_overflow |-> !out_item_o.window_match)
    else $error("overflow and match in one result");

endmodule

bind sliding_window_anagram_matcher_top swam_checker u_swam_checker (.*);
